>>> rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// Sparse set engine package
// Shared command and status codes, beat payloads and the table write bundle.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int KEY_W   = 10;
    localparam int SLOT_W  = 10;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 11;

    // Presence tags carry the clear epoch that wrote them; zero means absent.
    localparam int EPOCH_W = 3;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] TAG_ABSENT  = '0;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_PRESENT = 2'd2;
    localparam logic [STAT_W-1:0] ST_BEYOND      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              is_member;
        logic [KEY_W-1:0]  key_position;
        logic [KEY_W-1:0]  key_at_slot;
        logic [CNT_W-1:0]  member_count;
    } t_result;

    // One write per table per item; addresses and data are zero-extended.
    typedef struct packed {
        logic               tag_en;
        logic [KEY_W-1:0]   tag_addr;
        logic [EPOCH_W-1:0] tag_data;
        logic               pos_en;
        logic [KEY_W-1:0]   pos_addr;
        logic [KEY_W-1:0]   pos_data;
        logic               list_en;
        logic [KEY_W-1:0]   list_addr;
        logic [KEY_W-1:0]   list_data;
    } t_wr;

endpackage

>>> rtl/sse_chan_if.sv
// ----------------------------------------------------------------------------
// Sparse set engine channel
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface sse_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/sse_store.sv
// ----------------------------------------------------------------------------
// Sparse set engine table store
// Presence tag, position and member list memories with registered reads.
// ----------------------------------------------------------------------------
module sse_store import sse_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_key_raddr,
    input  logic [AW-1:0]      i_list_raddr,
    input  t_wr                i_wr,
    output logic [EPOCH_W-1:0] o_tag_q,
    output logic [AW-1:0]      o_pos_q,
    output logic [AW-1:0]      o_list_q
);

    logic [EPOCH_W-1:0] r_tag_mem  [DEPTH];
    logic [AW-1:0]      r_pos_mem  [DEPTH];
    logic [AW-1:0]      r_list_mem [DEPTH];

    logic [EPOCH_W-1:0] r_tag_q;
    logic [AW-1:0]      r_pos_q;
    logic [AW-1:0]      r_list_q;

    // A read in the same cycle as a write returns the old entry; the
    // execute stage forwards the last item's writes on top of that.
    always_ff @(posedge i_clk) begin
        if (i_wr.tag_en) begin
            r_tag_mem[i_wr.tag_addr[AW-1:0]] <= i_wr.tag_data;
        end
        if (i_rd_en) begin
            r_tag_q <= r_tag_mem[i_key_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.pos_en) begin
            r_pos_mem[i_wr.pos_addr[AW-1:0]] <= i_wr.pos_data[AW-1:0];
        end
        if (i_rd_en) begin
            r_pos_q <= r_pos_mem[i_key_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.list_en) begin
            r_list_mem[i_wr.list_addr[AW-1:0]] <= i_wr.list_data[AW-1:0];
        end
        if (i_rd_en) begin
            r_list_q <= r_list_mem[i_list_raddr];
        end
    end

    assign o_tag_q  = r_tag_q;
    assign o_pos_q  = r_pos_q;
    assign o_list_q = r_list_q;

endmodule

>>> rtl/sse_exec.sv
// ----------------------------------------------------------------------------
// Sparse set engine execute logic
// Forwards the previous item's writes, decides the command and forms the
// result, the table writes and the next member count.
// ----------------------------------------------------------------------------
module sse_exec import sse_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 11
) (
    input  t_item              i_item,
    input  logic [AW-1:0]      i_list_addr,
    input  logic [EPOCH_W-1:0] i_tag_q,
    input  logic [AW-1:0]      i_pos_q,
    input  logic [AW-1:0]      i_list_q,
    input  t_wr                i_last_wr,
    input  logic [CW-1:0]      i_count,
    input  logic [EPOCH_W-1:0] i_epoch,
    output t_result            o_result,
    output t_wr                o_wr,
    output logic [CW-1:0]      o_count
);

    logic [AW-1:0]      key_idx;
    logic               key_ok;
    logic [EPOCH_W-1:0] tag_b;
    logic [AW-1:0]      pos_b;
    logic [AW-1:0]      list_b;
    logic               member_pre;
    logic               member_post;
    logic               insert_done;
    logic [AW-1:0]      cnt_idx;

    assign key_idx = i_item.key[AW-1:0];
    assign key_ok  = {1'b0, i_item.key} < 11'(DEPTH);
    assign cnt_idx = i_count[AW-1:0];

    assign tag_b  = (i_last_wr.tag_en && i_last_wr.tag_addr[AW-1:0] == key_idx)
                    ? i_last_wr.tag_data : i_tag_q;
    assign pos_b  = (i_last_wr.pos_en && i_last_wr.pos_addr[AW-1:0] == key_idx)
                    ? i_last_wr.pos_data[AW-1:0] : i_pos_q;
    assign list_b = (i_last_wr.list_en && i_last_wr.list_addr[AW-1:0] == i_list_addr)
                    ? i_last_wr.list_data[AW-1:0] : i_list_q;

    assign member_pre = key_ok && (tag_b == i_epoch);

    always_comb begin
        o_wr                   = '0;
        o_count                = i_count;
        o_result               = '0;
        o_result.status        = ST_OK;
        member_post            = member_pre;
        insert_done            = 1'b0;
        case (i_item.cmd)
            CMD_INSERT: begin
                if (!key_ok) begin
                    o_result.status = ST_NOT_PRESENT;
                end else if (member_pre) begin
                    o_result.status = ST_PRESENT;
                end else if (i_count < CW'(DEPTH)) begin
                    insert_done    = 1'b1;
                    member_post    = 1'b1;
                    o_wr.list_en   = 1'b1;
                    o_wr.list_addr = KEY_W'(cnt_idx);
                    o_wr.list_data = KEY_W'(key_idx);
                    o_wr.pos_en    = 1'b1;
                    o_wr.pos_addr  = KEY_W'(key_idx);
                    o_wr.pos_data  = KEY_W'(cnt_idx);
                    o_wr.tag_en    = 1'b1;
                    o_wr.tag_addr  = KEY_W'(key_idx);
                    o_wr.tag_data  = i_epoch;
                    o_count        = i_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (!member_pre) begin
                    o_result.status = ST_NOT_PRESENT;
                end else begin
                    // The last member fills the freed slot.
                    member_post    = 1'b0;
                    o_wr.list_en   = 1'b1;
                    o_wr.list_addr = KEY_W'(pos_b);
                    o_wr.list_data = KEY_W'(list_b);
                    o_wr.pos_en    = 1'b1;
                    o_wr.pos_addr  = KEY_W'(list_b);
                    o_wr.pos_data  = KEY_W'(pos_b);
                    o_wr.tag_en    = 1'b1;
                    o_wr.tag_addr  = KEY_W'(key_idx);
                    o_wr.tag_data  = TAG_ABSENT;
                    o_count        = i_count - CW'(1);
                end
            end
            CMD_QUERY: begin
                if (!member_pre) begin
                    o_result.status = ST_NOT_PRESENT;
                end
            end
            CMD_READ: begin
                if ({1'b0, i_item.slot} >= 11'(i_count)) begin
                    o_result.status = ST_BEYOND;
                end else begin
                    o_result.key_at_slot = KEY_W'(list_b);
                end
            end
            CMD_CLEAR: begin
                member_post = 1'b0;
                o_count     = '0;
            end
            default: begin
            end
        endcase

        o_result.is_member = member_post;
        if (member_post) begin
            o_result.key_position = insert_done ? KEY_W'(cnt_idx) : KEY_W'(pos_b);
        end
        o_result.member_count = CNT_W'(o_count);
    end

endmodule

>>> rtl/sparse_set_engine_top.sv
// ----------------------------------------------------------------------------
// Sparse set engine
// Dense member list plus position table over small integer keys, with
// insert, remove, membership query, read by list position and clear.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                       | handshake
//  i_in     | in  | cmd, key, slot                                 | valid/ready
//  o_out    | out | status, is_member, key_position, key_at_slot,  | valid/ready
//           |     | member_count                                   |
//
// One beat is accepted per cycle unless a clearing pass, a wrapping clear or a
// stalled output holds i_in.ready low. Each accepted beat and its table reads
// are registered; it executes and loads the output register once that is free.
// After reset, and after every seventh clear, a clearing pass walks all DEPTH
// presence tags while i_in.ready stays low.
// A stalled output holds one result and the execute stage one more beat.
// ----------------------------------------------------------------------------
module sparse_set_engine_top import sse_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sse_chan_if.sink     i_in,
    sse_chan_if.source   o_out
);

    // Keys are ten bits wide, so no more than 1024 of them can be members.
    localparam int DEPTH = (CAPACITY < 1024) ? CAPACITY : 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_item              in_item;
    logic               in_fire;
    logic               e_fire;
    logic               e_wrap_clear;

    logic               r_e_valid;
    t_item              r_e_item;
    logic [AW-1:0]      r_e_list_addr;

    logic [CW-1:0]      r_count;
    logic [EPOCH_W-1:0] r_epoch;
    t_wr                r_last_wr;

    logic               r_sweep;
    logic [AW-1:0]      r_sweep_addr;

    logic               r_out_valid;
    t_result            r_out;

    logic [EPOCH_W-1:0] tag_q;
    logic [AW-1:0]      pos_q;
    logic [AW-1:0]      list_q;
    t_result            x_result;
    t_wr                x_wr;
    logic [CW-1:0]      x_count;
    t_wr                mem_wr;

    logic [CW-1:0]      cnt_now;
    logic [CW-1:0]      cnt_dec;
    logic [AW-1:0]      n_list_addr;
    logic [EPOCH_W-1:0] n_epoch;

    assign in_item      = i_in.payload;
    assign e_fire       = r_e_valid && (!r_out_valid || o_out.ready);
    assign e_wrap_clear = r_e_valid && (r_e_item.cmd == CMD_CLEAR) && (r_epoch == EPOCH_LAST);
    assign i_in.ready   = !r_sweep && !e_wrap_clear && (!r_e_valid || e_fire);
    assign in_fire      = i_in.valid && i_in.ready;

    // A remove reads the last member, using the count left by the beat
    // that executes in this same cycle.
    assign cnt_now     = r_e_valid ? x_count : r_count;
    assign cnt_dec     = cnt_now - CW'(1);
    assign n_list_addr = (in_item.cmd == CMD_REMOVE) ? cnt_dec[AW-1:0] : in_item.slot[AW-1:0];

    always_comb begin
        mem_wr = '0;
        if (r_sweep) begin
            mem_wr.tag_en   = 1'b1;
            mem_wr.tag_addr = KEY_W'(r_sweep_addr);
            mem_wr.tag_data = TAG_ABSENT;
        end else if (e_fire) begin
            mem_wr = x_wr;
        end
    end

    assign n_epoch = (r_epoch == EPOCH_LAST) ? EPOCH_FIRST : r_epoch + EPOCH_W'(1);

    sse_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_en      (in_fire),
        .i_key_raddr  (in_item.key[AW-1:0]),
        .i_list_raddr (n_list_addr),
        .i_wr         (mem_wr),
        .o_tag_q      (tag_q),
        .o_pos_q      (pos_q),
        .o_list_q     (list_q)
    );

    sse_exec #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_exec (
        .i_item      (r_e_item),
        .i_list_addr (r_e_list_addr),
        .i_tag_q     (tag_q),
        .i_pos_q     (pos_q),
        .i_list_q    (list_q),
        .i_last_wr   (r_last_wr),
        .i_count     (r_count),
        .i_epoch     (r_epoch),
        .o_result    (x_result),
        .o_wr        (x_wr),
        .o_count     (x_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (in_fire) begin
            r_e_valid <= 1'b1;
        end else if (e_fire) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_e_item      <= in_item;
            r_e_list_addr <= n_list_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_epoch      <= EPOCH_FIRST;
            r_last_wr    <= '0;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else begin
            if (e_fire) begin
                r_count   <= x_count;
                r_last_wr <= x_wr;
                if (r_e_item.cmd == CMD_CLEAR) begin
                    r_epoch <= n_epoch;
                end
            end
            if (e_fire && e_wrap_clear) begin
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweep) begin
                if (r_sweep_addr == AW'(DEPTH - 1)) begin
                    r_sweep <= 1'b0;
                end else begin
                    r_sweep_addr <= r_sweep_addr + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (e_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_out <= x_result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse set engine testbench
// Drives insert, remove, query, read, clear and spare commands into the engine with
// bursty input and a stalling output. Every accepted command updates a local
// copy of the member list, position table and presence bits. The expected
// result is queued, and each output beat is compared with it field by field.
// ----------------------------------------------------------------------------
module tb;
    import sse_pkg::*;

    localparam int SET_CAP      = 1024;
    localparam int RANDOM_ITEMS = 925;
    localparam int HOLD_AT      = 250;   // accepted beats before the long output stall
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 600;   // accepted beats before the input waits for results
    localparam int TAIL_CYCLES  = 16;

    // Command codes the engine treats as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_SCAN} t_mix;
    typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} t_rx_style;

    logic i_clk;
    logic i_rst_n;

    sse_chan_if #(.t_payload(t_item))   in_ch ();
    sse_chan_if #(.t_payload(t_result)) out_ch ();

    sparse_set_engine_top #(.CAPACITY(SET_CAP)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Local copy of the set.
    bit               in_set   [SET_CAP];
    logic [KEY_W-1:0] slot_of  [SET_CAP];
    logic [KEY_W-1:0] members  [SET_CAP];
    logic [CNT_W-1:0] set_size = '0;

    t_item            cmd_backlog[$];
    t_result          awaited_results[$];
    logic [KEY_W-1:0] issued_keys[$];    // keys sent with insert, to aim removes and queries

    int total_items   = 0;
    int beats_sent    = 0;
    int mismatch_count = 0;

    // ------------------------------------------------------------------
    // Set operation and the result it produces
    // ------------------------------------------------------------------
    function automatic t_result apply_set_op(t_item it);
        t_result          r;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] hole;
        logic [KEY_W-1:0] tail_key;
        r = '0;
        k = it.key;
        case (it.cmd)
            CMD_INSERT: begin
                if (in_set[k]) begin
                    r.status = ST_PRESENT;
                end else if (set_size < SET_CAP) begin
                    members[set_size] = k;
                    slot_of[k]        = set_size[KEY_W-1:0];
                    in_set[k]         = 1'b1;
                    set_size          = set_size + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!in_set[k]) begin
                    r.status = ST_NOT_PRESENT;
                end else begin
                    // The last member fills the slot that the removed key leaves.
                    hole              = slot_of[k];
                    tail_key          = members[set_size - 1'b1];
                    members[hole]     = tail_key;
                    slot_of[tail_key] = hole;
                    in_set[k]         = 1'b0;
                    set_size          = set_size - 1'b1;
                end
            end
            CMD_QUERY: begin
                if (!in_set[k]) r.status = ST_NOT_PRESENT;
            end
            CMD_READ: begin
                if (it.slot >= set_size) r.status = ST_BEYOND;
                else r.key_at_slot = members[it.slot];
            end
            CMD_CLEAR: begin
                in_set   = '{default: 1'b0};
                set_size = '0;
            end
            default: ;
        endcase
        r.is_member    = in_set[k];
        r.key_position = in_set[k] ? slot_of[k] : '0;
        r.member_count = set_size;
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                       logic [SLOT_W-1:0] s);
        t_item it;
        it.cmd  = c;
        it.key  = k;
        it.slot = s;
        cmd_backlog.push_back(it);
        total_items++;
        if (c == CMD_INSERT) issued_keys.push_back(k);
        if (c == CMD_CLEAR) issued_keys.delete();
    endfunction

    // A key sent earlier with insert, dropped from the list when a remove takes it.
    function automatic logic [KEY_W-1:0] recall_key(bit consume);
        int               idx;
        logic [KEY_W-1:0] k;
        if (issued_keys.size() == 0) return KEY_W'($urandom_range(0, SET_CAP - 1));
        idx = $urandom_range(0, issued_keys.size() - 1);
        k   = issued_keys[idx];
        if (consume) issued_keys.delete(idx);
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        t_mix             mix;
        int               seg_left;
        int               roll;
        int               cut [4][5];
        logic [KEY_W-1:0] hot_base;
        logic [KEY_W-1:0] k;
        logic [SLOT_W-1:0] s;
        logic [CMD_W-1:0] c;

        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;

        // Cumulative weights: insert, remove, query, read, spare codes; the rest clears.
        cut[MIX_FILL]  = '{70, 78, 86, 98, 100};
        cut[MIX_CHURN] = '{35, 65, 80, 92, 97};
        cut[MIX_DRAIN] = '{15, 70, 80, 95, 99};
        cut[MIX_SCAN]  = '{10, 20, 40, 98, 100};

        // Directed opening: empty set, extremes, duplicates, misses, moves and clears.
        queue_item(CMD_QUERY,  10'd0,    10'd0);
        queue_item(CMD_READ,   10'd0,    10'd0);
        queue_item(CMD_REMOVE, 10'd1023, 10'd1023);
        queue_item(CMD_INSERT, 10'd0,    10'd0);
        queue_item(CMD_INSERT, 10'd1023, 10'd0);
        queue_item(CMD_INSERT, 10'd0,    10'd1023);
        queue_item(CMD_INSERT, 10'd682,  10'd0);
        queue_item(CMD_INSERT, 10'd341,  10'd0);
        queue_item(CMD_QUERY,  10'd1023, 10'd0);
        queue_item(CMD_READ,   10'd682,  10'd3);
        queue_item(CMD_READ,   10'd0,    10'd4);
        queue_item(CMD_READ,   10'd0,    10'd1023);
        queue_item(CMD_REMOVE, 10'd0,    10'd0);
        queue_item(CMD_REMOVE, 10'd682,  10'd0);
        queue_item(CMD_READ,   10'd341,  10'd0);
        queue_item(CMD_SPARE_5, 10'd1023, 10'd0);
        queue_item(CMD_SPARE_6, 10'd0,    10'd1023);
        queue_item(CMD_SPARE_7, 10'd341,  10'd682);
        queue_item(CMD_READ,   10'd1023, 10'd1);
        queue_item(CMD_CLEAR,  10'd0,    10'd0);
        queue_item(CMD_QUERY,  10'd1023, 10'd0);
        queue_item(CMD_INSERT, 10'd1023, 10'd0);
        queue_item(CMD_CLEAR,  10'd1023, 10'd1023);
        queue_item(CMD_CLEAR,  10'd0,    10'd0);
        queue_item(CMD_INSERT, 10'd512,  10'd0);

        // Random part in segments, each with its own command mix.
        seg_left = 0;
        mix      = MIX_FILL;
        hot_base = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 160);
                mix      = t_mix'($urandom_range(0, 3));
                hot_base = KEY_W'($urandom_range(0, SET_CAP - 32));
                if ($urandom_range(0, 2) == 0) begin
                    queue_item(CMD_CLEAR, KEY_W'($urandom), SLOT_W'($urandom));
                    continue;
                end
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            k    = KEY_W'($urandom_range(0, SET_CAP - 1));
            s    = SLOT_W'($urandom);
            if (roll < cut[mix][0]) begin
                c = CMD_INSERT;
                if (mix == MIX_CHURN) k = hot_base + KEY_W'($urandom_range(0, 31));
                else if ($urandom_range(0, 6) == 0) k = recall_key(1'b0);
            end else if (roll < cut[mix][1]) begin
                c = CMD_REMOVE;
                if ($urandom_range(0, 3) != 0) k = recall_key(1'b1);
                else if (mix == MIX_CHURN) k = hot_base + KEY_W'($urandom_range(0, 31));
            end else if (roll < cut[mix][2]) begin
                c = CMD_QUERY;
                if ($urandom_range(0, 3) != 0) k = recall_key(1'b0);
            end else if (roll < cut[mix][3]) begin
                c = CMD_READ;
                if ($urandom_range(0, 9) != 0)
                    s = SLOT_W'($urandom_range(0, (issued_keys.size() + 3 > SET_CAP - 1) ?
                                                  SET_CAP - 1 : issued_keys.size() + 3));
                if ($urandom_range(0, 1) == 0) k = recall_key(1'b0);
            end else if (roll < cut[mix][4]) begin
                case ($urandom_range(0, 2))
                    0:       c = CMD_SPARE_5;
                    1:       c = CMD_SPARE_6;
                    default: c = CMD_SPARE_7;
                endcase
                if ($urandom_range(0, 1) == 0) k = recall_key(1'b0);
            end else begin
                c = CMD_CLEAR;
            end
            queue_item(c, k, s);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_sent != total_items || awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[sparse_set_engine_top] OK");
        end else begin
            $display("[sparse_set_engine_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[sparse_set_engine_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: bursts of beats with random gaps, one pause for a full drain
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;
    bit drain_done = 1'b0;

    always @(posedge i_clk) begin
        bit fire;
        bit next_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            fire = in_ch.valid && in_ch.ready;
            if (fire) begin
                awaited_results.push_back(apply_set_op(in_ch.payload));
                beats_sent++;
            end
            // An offered beat stays on the channel until it is taken.
            if (!in_ch.valid || fire) begin
                next_valid = 1'b0;
                if (!drain_done && beats_sent == DRAIN_AT) begin
                    if (awaited_results.size() == 0) drain_done = 1'b1;
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() != 0) begin
                    next_valid    = 1'b1;
                    in_ch.payload <= cmd_backlog.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
                in_ch.valid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: stall pattern that changes style, plus one long hold-off
    // ------------------------------------------------------------------
    t_rx_style rx_style  = RX_OPEN;
    int        style_left = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    rx_style   = t_rx_style'($urandom_range(0, 3));
                    style_left = $urandom_range(16, 120);
                end else begin
                    style_left--;
                end
                case (rx_style)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_HALF:   out_ch.ready <= $urandom_range(0, 1);
                    RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default:   out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result beat %h with nothing outstanding", got));
            end else begin
                want = awaited_results.pop_front();
                check_field("status",       CNT_W'(got.status),       CNT_W'(want.status));
                check_field("is_member",    CNT_W'(got.is_member),    CNT_W'(want.is_member));
                check_field("key_position", CNT_W'(got.key_position), CNT_W'(want.key_position));
                check_field("key_at_slot",  CNT_W'(got.key_at_slot),  CNT_W'(want.key_at_slot));
                check_field("member_count", got.member_count,         want.member_count);
            end
        end
    end

endmodule

>>> sparse_set_engine_top.f
rtl/sse_pkg.sv
rtl/sse_chan_if.sv
rtl/sse_store.sv
rtl/sse_exec.sv
rtl/sparse_set_engine_top.sv
sim/tb.sv
